### rtl/prefix_client_table_assert.svh
// assertion macros for the prefix client table
`ifndef PREFIX_CLIENT_TABLE_ASSERT_SVH
`define PREFIX_CLIENT_TABLE_ASSERT_SVH

// same-cycle implication
`define PCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pct_pkg.sv
`timescale 1ns / 1ps
package pct_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ADDR_W   = 128;
   localparam int LEN_W    = 8;
   localparam int COST_W   = 8;
   localparam int FULL_LEN = 128;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_DELETE,
      OP_FIND,
      OP_GET
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_INVALID,
      STATUS_EXISTS,
      STATUS_NOT_FOUND,
      STATUS_FULL
   } status_type;

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      LAST,
      COMMIT,
      RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [COST_W-1:0] cost;
   } entry_type;

   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             commit;
   } cmd_type;

   typedef struct packed {
      logic req_invalid;
   } stat_type;

   // leading-ones mask for a prefix length of 0..128
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] mask;
      if (len >= LEN_W'(FULL_LEN)) begin
         mask = {ADDR_W{1'b1}};
      end else begin
         mask = ~({ADDR_W{1'b1}} >> len);
      end
      return mask;
   endfunction

endpackage

### rtl/pct_ctrl.sv
`timescale 1ns / 1ps
module pct_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pct_pkg::stat_type  stat,
   output pct_pkg::cmd_type   cmd
);

   pct_pkg::state_type            state_ff, state_in;
   logic [pct_pkg::IDX_W-1:0]     cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pct_pkg::IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         pct_pkg::IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.req_invalid ? pct_pkg::COMMIT : pct_pkg::SCAN;
            end
         end
         pct_pkg::SCAN: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == pct_pkg::IDX_W'(pct_pkg::ENTRIES - 1)) begin
               state_in = pct_pkg::LAST;
            end
         end
         pct_pkg::LAST: begin
            state_in = pct_pkg::COMMIT;
         end
         pct_pkg::COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = pct_pkg::RESP;
         end
         pct_pkg::RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = pct_pkg::IDLE;
            end
         end
         default: begin
            state_in = pct_pkg::IDLE;
         end
      endcase
   end

endmodule

### rtl/pct_datapath.sv
`timescale 1ns / 1ps
module pct_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  req_op,
   input  logic [63:0]                 req_addr_high,
   input  logic [63:0]                 req_addr_low,
   input  logic [pct_pkg::LEN_W-1:0]   req_prefix_len,
   input  logic [pct_pkg::COST_W-1:0]  req_cost,
   input  pct_pkg::cmd_type            cmd,
   output pct_pkg::stat_type           stat,
   output logic [2:0]                  rsp_status,
   output logic [63:0]                 rsp_out_addr_high,
   output logic [63:0]                 rsp_out_addr_low,
   output logic [pct_pkg::LEN_W-1:0]   rsp_out_prefix_len,
   output logic [pct_pkg::COST_W-1:0]  rsp_out_cost
);

   // captured request
   pct_pkg::op_type                op_ff;
   logic [pct_pkg::ADDR_W-1:0]     addr_ff;
   logic [pct_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [pct_pkg::COST_W-1:0]     cost_ff;
   logic                           invalid_ff;

   // table storage
   logic [pct_pkg::ENTRIES-1:0]    slot_valid_ff;
   pct_pkg::entry_type             slot_mem [pct_pkg::ENTRIES];

   // registered read port
   logic                           rd_vld_ff;
   logic [pct_pkg::IDX_W-1:0]      rd_idx_ff;
   logic                           rd_valid_ff;
   pct_pkg::entry_type             rd_entry_ff;

   // scan results
   logic                           best_hit_ff;
   logic [pct_pkg::IDX_W-1:0]      best_idx_ff;
   pct_pkg::entry_type             best_entry_ff;
   logic                           free_hit_ff;
   logic [pct_pkg::IDX_W-1:0]      free_idx_ff;

   // response
   pct_pkg::status_type            rsp_status_ff, status_in;
   pct_pkg::entry_type             rsp_entry_ff, rsp_entry_in;

   logic [pct_pkg::ADDR_W-1:0]     req_mask;
   logic [pct_pkg::ADDR_W-1:0]     slot_mask;
   logic                           exact_hit;
   logic                           lpm_hit;
   logic                           take_best;
   logic                           take_free;
   logic                           do_add;
   logic                           do_delete;

   assign stat.req_invalid = ({req_addr_high, req_addr_low} == '0) ||
                             ((pct_pkg::op_type'(req_op) != pct_pkg::OP_GET) &&
                              (req_prefix_len == '0));

   assign len_in = (req_prefix_len > pct_pkg::LEN_W'(pct_pkg::FULL_LEN)) ?
                   pct_pkg::LEN_W'(pct_pkg::FULL_LEN) : req_prefix_len;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= pct_pkg::op_type'(req_op);
         addr_ff    <= {req_addr_high, req_addr_low};
         len_ff     <= len_in;
         cost_ff    <= req_cost;
         invalid_ff <= stat.req_invalid;
      end
   end

   // compare of the slot read in the previous cycle
   always_comb begin
      req_mask  = pct_pkg::prefix_mask(len_ff);
      slot_mask = pct_pkg::prefix_mask(rd_entry_ff.len);
      exact_hit = rd_valid_ff && (rd_entry_ff.len == len_ff) &&
                  (((rd_entry_ff.addr ^ addr_ff) & req_mask) == '0);
      lpm_hit   = rd_valid_ff && (((rd_entry_ff.addr ^ addr_ff) & slot_mask) == '0);
      if (op_ff == pct_pkg::OP_GET) begin
         take_best = rd_vld_ff && lpm_hit &&
                     (!best_hit_ff || (rd_entry_ff.len > best_entry_ff.len));
      end else begin
         take_best = rd_vld_ff && exact_hit && !best_hit_ff;
      end
      take_free = rd_vld_ff && !rd_valid_ff && !free_hit_ff;
   end

   // outcome of the transaction
   always_comb begin
      status_in    = pct_pkg::STATUS_OK;
      rsp_entry_in = '0;
      do_add       = 1'b0;
      do_delete    = 1'b0;
      if (invalid_ff) begin
         status_in = pct_pkg::STATUS_INVALID;
      end else begin
         case (op_ff)
            pct_pkg::OP_ADD: begin
               if (best_hit_ff) begin
                  status_in = pct_pkg::STATUS_EXISTS;
               end else if (free_hit_ff) begin
                  do_add = 1'b1;
               end else begin
                  status_in = pct_pkg::STATUS_FULL;
               end
            end
            pct_pkg::OP_DELETE: begin
               if (best_hit_ff) begin
                  do_delete = 1'b1;
               end else begin
                  status_in = pct_pkg::STATUS_NOT_FOUND;
               end
            end
            default: begin
               if (best_hit_ff) begin
                  rsp_entry_in = best_entry_ff;
               end else begin
                  status_in = pct_pkg::STATUS_NOT_FOUND;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_vld_ff     <= 1'b0;
         best_hit_ff   <= 1'b0;
         free_hit_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         if (cmd.load) begin
            best_hit_ff <= 1'b0;
            free_hit_ff <= 1'b0;
         end else begin
            if (take_best) begin
               best_hit_ff <= 1'b1;
            end
            if (take_free) begin
               free_hit_ff <= 1'b1;
            end
         end
         if (cmd.commit && do_add) begin
            slot_valid_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.commit && do_delete) begin
            slot_valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cmd.rd_idx;
      if (cmd.rd_en) begin
         rd_valid_ff <= slot_valid_ff[cmd.rd_idx];
      end
      if (take_best) begin
         best_idx_ff   <= rd_idx_ff;
         best_entry_ff <= rd_entry_ff;
      end
      if (take_free) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_entry_ff  <= rsp_entry_in;
      end
   end

   // slot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && do_add) begin
         slot_mem[free_idx_ff] <= pct_pkg::entry_type'{
            addr: addr_ff & req_mask,
            len:  len_ff,
            cost: cost_ff
         };
      end
      if (cmd.rd_en) begin
         rd_entry_ff <= slot_mem[cmd.rd_idx];
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_out_addr_high  = rsp_entry_ff.addr[127:64];
   assign rsp_out_addr_low   = rsp_entry_ff.addr[63:0];
   assign rsp_out_prefix_len = rsp_entry_ff.len;
   assign rsp_out_cost       = rsp_entry_ff.cost;

endmodule

### rtl/prefix_client_table.sv
`timescale 1ns / 1ps
// channel   handshake              payload
// req       req_valid / req_stall  req_op, req_addr_high, req_addr_low,
//                                  req_prefix_len, req_cost
// rsp       rsp_valid / rsp_stall  rsp_status, rsp_out_addr_high, rsp_out_addr_low,
//                                  rsp_out_prefix_len, rsp_out_cost
//
// one transaction at a time: a request scans every slot before it commits and responds,
// one slot read and compared per cycle
// an invalid request (zero address, or zero length other than get) skips the scan
// rsp_stall holds the response and req_stall stays high until it is taken
// synchronous reset clears the slot valid bits at once, no clearing pass
module prefix_client_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_op,
   input  logic [63:0]                 req_addr_high,
   input  logic [63:0]                 req_addr_low,
   input  logic [pct_pkg::LEN_W-1:0]   req_prefix_len,
   input  logic [pct_pkg::COST_W-1:0]  req_cost,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [63:0]                 rsp_out_addr_high,
   output logic [63:0]                 rsp_out_addr_low,
   output logic [pct_pkg::LEN_W-1:0]   rsp_out_prefix_len,
   output logic [pct_pkg::COST_W-1:0]  rsp_out_cost
);

   `include "prefix_client_table_assert.svh"

   pct_pkg::cmd_type   cmd;
   pct_pkg::stat_type  stat;
   logic               req_take;
   logic               rsp_fail;
   logic               rsp_blank;
   logic               len_ok;

   pct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pct_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_addr_high      (req_addr_high),
      .req_addr_low       (req_addr_low),
      .req_prefix_len     (req_prefix_len),
      .req_cost           (req_cost),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_out_addr_high  (rsp_out_addr_high),
      .rsp_out_addr_low   (rsp_out_addr_low),
      .rsp_out_prefix_len (rsp_out_prefix_len),
      .rsp_out_cost       (rsp_out_cost)
   );

   assign req_take  = req_valid && !req_stall;
   assign rsp_fail  = rsp_valid && (rsp_status != pct_pkg::STATUS_OK);
   assign rsp_blank = (rsp_out_addr_high == '0) && (rsp_out_addr_low == '0) &&
                      (rsp_out_prefix_len == '0) && (rsp_out_cost == '0);
   assign len_ok    = rsp_out_prefix_len <= pct_pkg::LEN_W'(pct_pkg::FULL_LEN);

   `PCT_ASSERT_NXT(a_no_early_rsp, clock, reset, req_take, !rsp_valid, "early response")
   `PCT_ASSERT_IMP(a_one_in_flight, clock, reset, rsp_valid, req_stall, "request during response")
   `PCT_ASSERT_IMP(a_fail_zero, clock, reset, rsp_fail, rsp_blank, "entry fields set on failure")
   `PCT_ASSERT_IMP(a_len_range, clock, reset, rsp_valid, len_ok, "prefix length above full length")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   typedef struct {
      pct_pkg::status_type status;
      logic [63:0]         addr_high;
      logic [63:0]         addr_low;
      logic [7:0]          prefix_len;
      logic [7:0]          cost;
   } answer_type;

   class scoreboard_type;
      bit           slot_used [pct_pkg::ENTRIES];
      logic [127:0] slot_addr [pct_pkg::ENTRIES];
      logic [7:0]   slot_len  [pct_pkg::ENTRIES];
      logic [7:0]   slot_cost [pct_pkg::ENTRIES];
      answer_type   pending [$];
      int           errors;

      function logic [127:0] lead_mask(int unsigned len);
         if (len == 0) return '0;
         return ~((128'd1 << (128 - len)) - 128'd1);
      endfunction

      function bit covers(int s, logic [127:0] addr, int unsigned len);
         return ((slot_addr[s] ^ addr) & lead_mask(len)) == '0;
      endfunction

      function int exact_slot(logic [127:0] addr, int unsigned len);
         for (int i = 0; i < pct_pkg::ENTRIES; i++) begin
            if (slot_used[i] && slot_len[i] == len && covers(i, addr, len)) return i;
         end
         return -1;
      endfunction

      function answer_type entry_answer(int s);
         return '{pct_pkg::STATUS_OK, slot_addr[s][127:64], slot_addr[s][63:0], slot_len[s],
                  slot_cost[s]};
      endfunction

      function void note_request(pct_pkg::op_type op, logic [63:0] ah, logic [63:0] al,
                                 logic [7:0] len_in, logic [7:0] cost);
         answer_type   ans;
         logic [127:0] addr;
         int unsigned  len;
         int           hit;
         int           free;
         ans  = '{pct_pkg::STATUS_OK, 64'h0, 64'h0, 8'h0, 8'h0};
         addr = {ah, al};
         len  = len_in;
         hit  = -1;
         free = -1;
         if (addr == '0) begin
            ans.status = pct_pkg::STATUS_INVALID;
         end else if (op == pct_pkg::OP_GET) begin
            for (int i = 0; i < pct_pkg::ENTRIES; i++) begin
               if (slot_used[i] && covers(i, addr, slot_len[i]) &&
                   (hit < 0 || slot_len[hit] < slot_len[i])) hit = i;
            end
            if (hit < 0) ans.status = pct_pkg::STATUS_NOT_FOUND;
            else ans = entry_answer(hit);
         end else if (len == 0) begin
            ans.status = pct_pkg::STATUS_INVALID;
         end else begin
            if (len > pct_pkg::FULL_LEN) len = pct_pkg::FULL_LEN;
            hit = exact_slot(addr, len);
            case (op)
               pct_pkg::OP_ADD: begin
                  if (hit >= 0) begin
                     ans.status = pct_pkg::STATUS_EXISTS;
                  end else begin
                     for (int i = pct_pkg::ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_used[i]) free = i;
                     end
                     if (free < 0) begin
                        ans.status = pct_pkg::STATUS_FULL;
                     end else begin
                        slot_used[free] = 1'b1;
                        slot_addr[free] = addr & lead_mask(len);
                        slot_len[free]  = 8'(len);
                        slot_cost[free] = cost;
                     end
                  end
               end
               pct_pkg::OP_DELETE: begin
                  if (hit < 0) ans.status = pct_pkg::STATUS_NOT_FOUND;
                  else slot_used[hit] = 1'b0;
               end
               default: begin
                  if (hit < 0) ans.status = pct_pkg::STATUS_NOT_FOUND;
                  else ans = entry_answer(hit);
               end
            endcase
         end
         pending.push_back(ans);
      endfunction

      function void check_response(answer_type got);
         answer_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response with nothing outstanding: status %0d",
                                       got.status);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.addr_high !== want.addr_high ||
             got.addr_low !== want.addr_low || got.prefix_len !== want.prefix_len ||
             got.cost !== want.cost) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch exp/act: status %0d/%0d addr %h_%h/%h_%h",
                         " len %0d/%0d cost %0d/%0d"},
                        want.status, got.status, want.addr_high, want.addr_low,
                        got.addr_high, got.addr_low, want.prefix_len, got.prefix_len,
                        want.cost, got.cost);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [63:0] req_addr_high = '0;
   logic [63:0] req_addr_low = '0;
   logic [pct_pkg::LEN_W-1:0]  req_prefix_len = '0;
   logic [pct_pkg::COST_W-1:0] req_cost = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_out_addr_high;
   logic [63:0] rsp_out_addr_low;
   logic [pct_pkg::LEN_W-1:0]  rsp_out_prefix_len;
   logic [pct_pkg::COST_W-1:0] rsp_out_cost;

   scoreboard_type sb = new();
   bit quiet_send;

   prefix_client_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_addr_high      (req_addr_high),
      .req_addr_low       (req_addr_low),
      .req_prefix_len     (req_prefix_len),
      .req_cost           (req_cost),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_addr_high  (rsp_out_addr_high),
      .rsp_out_addr_low   (rsp_out_addr_low),
      .rsp_out_prefix_len (rsp_out_prefix_len),
      .rsp_out_cost       (rsp_out_cost)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(answer_type'{pct_pkg::status_type'(rsp_status), rsp_out_addr_high,
                                        rsp_out_addr_low, rsp_out_prefix_len, rsp_out_cost});
      if (!reset && req_valid && !req_stall)
         sb.note_request(pct_pkg::op_type'(req_op), req_addr_high, req_addr_low,
                         req_prefix_len, req_cost);
   end

   task automatic offer(pct_pkg::op_type op, logic [63:0] ah, logic [63:0] al,
                        logic [7:0] len, logic [7:0] cost);
      int unsigned gap;
      gap = quiet_send ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_addr_high  <= ah;
      req_addr_low   <= al;
      req_prefix_len <= len;
      req_cost       <= cost;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random hold-off per transaction, none in some windows, one long hold to back up the request side
   initial begin
      int unsigned hold;
      int          taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 300) hold = 400;
         else if ((taken / 50) % 5 == 2) hold = 0;
         else hold = $urandom_range(0, 13);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      logic [127:0]    base [4];
      logic [127:0]    pool_addr [24];
      logic [7:0]      pool_len [24];
      logic [127:0]    addr;
      logic [127:0]    suffix;
      logic [7:0]      len;
      int unsigned     p;
      int unsigned     k;
      pct_pkg::op_type op;

      for (int i = 0; i < 4; i++) begin
         base[i] = {$urandom, $urandom, $urandom, $urandom};
         if (base[i] == '0) base[i] = 128'h1;
      end
      for (int i = 0; i < 24; i++) begin
         pool_addr[i] = base[i % 4];
         case (i)
            0:       pool_len[i] = 8'd1;
            1:       pool_len[i] = 8'd63;
            2:       pool_len[i] = 8'd64;
            3:       pool_len[i] = 8'd65;
            4:       pool_len[i] = 8'd127;
            5:       pool_len[i] = 8'd128;
            default: pool_len[i] = 8'($urandom_range(1, 128));
         endcase
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, invalid requests, nesting, saturation, masking
      offer(pct_pkg::OP_GET, 64'h8000_0000_0000_0000, 64'h0, 8'd0, 8'd0);
      offer(pct_pkg::OP_ADD, 64'h0, 64'h0, 8'd64, 8'hFF);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd0, 8'd1);
      offer(pct_pkg::OP_DELETE, 64'h0, 64'h0, 8'd8, 8'd0);
      offer(pct_pkg::OP_FIND, 64'h0, 64'h0, 8'd128, 8'd0);
      offer(pct_pkg::OP_GET, 64'h0, 64'h0, 8'd0, 8'd0);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd1, 8'h00);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd64, 8'h11);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd65, 8'h22);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd128, 8'hFF);
      offer(pct_pkg::OP_ADD, '1, '1, 8'd255, 8'h33);
      offer(pct_pkg::OP_ADD, '1, 64'h0123_4567_89AB_CDEF, 8'd64, 8'h44);
      offer(pct_pkg::OP_GET, '1, '1, 8'd0, 8'd0);
      offer(pct_pkg::OP_GET, '1, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 8'd0);
      offer(pct_pkg::OP_GET, 64'h8000_0000_0000_0000, 64'h1, 8'd0, 8'd0);
      offer(pct_pkg::OP_FIND, '1, 64'h8000_0000_0000_0000, 8'd65, 8'd0);
      offer(pct_pkg::OP_DELETE, '1, '1, 8'd65, 8'd0);
      offer(pct_pkg::OP_DELETE, '1, '1, 8'd65, 8'd0);
      offer(pct_pkg::OP_FIND, '1, '1, 8'd200, 8'd0);
      offer(pct_pkg::OP_GET, 64'h1, 64'h0, 8'd77, 8'd0);
      offer(pct_pkg::OP_ADD, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd127,
            8'h80);
      offer(pct_pkg::OP_FIND, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 8'd127,
            8'd0);

      for (int n = 0; n < 980; n++) begin
         quiet_send = ((n / 64) % 4 == 1);
         k = $urandom_range(0, 99);
         if (k < 6) begin
            offer(pct_pkg::op_type'($urandom_range(0, 3)), {$urandom, $urandom},
                  {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
         end else if (k < 9) begin
            offer(pct_pkg::op_type'($urandom_range(0, 3)), 64'h0, 64'h0,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (k < 12) begin
            p = $urandom_range(0, 23);
            offer(pct_pkg::op_type'($urandom_range(0, 3)), pool_addr[p][127:64],
                  pool_addr[p][63:0], 8'd0, 8'($urandom_range(0, 255)));
         end else begin
            p      = $urandom_range(0, 23);
            suffix = {$urandom, $urandom, $urandom, $urandom};
            addr   = pool_addr[p] ^ (suffix & ~sb.lead_mask(pool_len[p]));
            len    = pool_len[p];
            if (len == 8'd128 && $urandom_range(0, 1)) len = 8'($urandom_range(129, 255));
            k = $urandom_range(0, 99);
            if (k < 35) op = pct_pkg::OP_ADD;
            else if (k < 55) op = pct_pkg::OP_DELETE;
            else if (k < 75) op = pct_pkg::OP_FIND;
            else begin
               op  = pct_pkg::OP_GET;
               len = 8'($urandom_range(0, 255));
            end
            offer(op, addr[127:64], addr[63:0], len, 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/pct_pkg.sv
rtl/pct_ctrl.sv
rtl/pct_datapath.sv
rtl/prefix_client_table.sv
bench/tb_top.sv
